FILE: sv/rgbc_pkg.sv
// Shared constants, register codes and types of the RGB 3x3 convolution block.
package rgbc_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int COEF_FRAC_DEF = 12;
    localparam int HEIGHT_LIMIT  = 4096;

    localparam int W_W    = 11;
    localparam int H_W    = 13;
    localparam int ROW_W  = 12;
    localparam int K_W    = 48;
    localparam int COEF_W = 16;
    localparam int PIX_W  = 24;
    localparam int TAPS   = 9;
    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_KTOP   = 3'd2;
    localparam logic [2:0] REG_KMID   = 3'd3;
    localparam logic [2:0] REG_KBOT   = 3'd4;

    localparam logic [W_W-1:0] WIDTH_RST  = 11'd1;
    localparam logic [H_W-1:0] HEIGHT_RST = 13'd1;
    localparam logic [K_W-1:0] KTOP_RST   = 48'd0;
    localparam logic [K_W-1:0] KMID_RST   = 48'h0000_1000_0000;
    localparam logic [K_W-1:0] KBOT_RST   = 48'd0;

    typedef struct packed {
        logic [W_W-1:0] width;
        logic [H_W-1:0] height;
        logic [K_W-1:0] k_top;
        logic [K_W-1:0] k_mid;
        logic [K_W-1:0] k_bot;
    } cfg_t;

    typedef struct packed {
        logic             valid;
        logic             feed;
        logic             emit;
        logic             last;
        logic [PIX_W-1:0] pix;
        logic [TAPS-1:0]  mask;
    } step_t;

endpackage

FILE: sv/rgbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rgbc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: sv/rgbc_regs.sv
// APB register file holding frame geometry and kernel rows.
module rgbc_regs import rgbc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic [2:0] index;
    logic       wr;

    assign index = paddr[ADDR_W-1:3];
    assign wr    = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width  <= WIDTH_RST;
            cfg_reg.height <= HEIGHT_RST;
            cfg_reg.k_top  <= KTOP_RST;
            cfg_reg.k_mid  <= KMID_RST;
            cfg_reg.k_bot  <= KBOT_RST;
        end
        else if (wr)
        begin
            unique case (index)
                REG_WIDTH:  cfg_reg.width  <= pwdata[W_W-1:0];
                REG_HEIGHT: cfg_reg.height <= pwdata[H_W-1:0];
                REG_KTOP:   cfg_reg.k_top  <= pwdata[K_W-1:0];
                REG_KMID:   cfg_reg.k_mid  <= pwdata[K_W-1:0];
                REG_KBOT:   cfg_reg.k_bot  <= pwdata[K_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_WIDTH:  prdata = DATA_W'(cfg_reg.width);
            REG_HEIGHT: prdata = DATA_W'(cfg_reg.height);
            REG_KTOP:   prdata = DATA_W'(cfg_reg.k_top);
            REG_KMID:   prdata = DATA_W'(cfg_reg.k_mid);
            REG_KBOT:   prdata = DATA_W'(cfg_reg.k_bot);
            default:    prdata = '0;
        endcase
    end

endmodule

FILE: sv/rgbc_ctrl.sv
// Raster position tracking, drain sequencing, line store addressing and tap masks.
module rgbc_ctrl import rgbc_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cfg_t                         cfg,
    input  logic                         in_valid,
    input  logic                         in_kind,
    input  logic [PIX_W-1:0]             in_pix,
    input  logic                         adv,
    output logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    output step_t                        s1_step,
    output logic [$clog2(MAX_WIDTH)-1:0] s1_addr
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 2);
    localparam int EW = (WW > W_W) ? WW : W_W + 1;

    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [WW-1:0]    pend_reg, pend_next;

    logic [EW-1:0]  w_ext;
    logic [WW-1:0]  w, w1, pend_c, d;
    logic [H_W-1:0] h, r_try, r;
    logic           wrap, accept;
    logic [CW-1:0]  c, addr;
    logic           top_ok, bot_ok, left_ok, right_ok;
    logic [2:0]     rok, cok;
    step_t          step;

    assign accept  = in_valid && adv;
    assign rd_addr = addr;

    always_comb
    begin
        w_ext = EW'(cfg.width);
        if (w_ext == '0)
            w = WW'(1);
        else if (w_ext > EW'(MAX_WIDTH))
            w = WW'(MAX_WIDTH);
        else
            w = WW'(w_ext);
        if (cfg.height == '0)
            h = H_W'(1);
        else if (cfg.height > H_W'(HEIGHT_LIMIT))
            h = H_W'(HEIGHT_LIMIT);
        else
            h = cfg.height;

        w1     = w + WW'(1);
        pend_c = (pend_reg > w1) ? w1 : pend_reg;
        d      = w1 - pend_c;

        // a column past the width starts the next row; a row past the height is pulled back
        wrap  = WW'(col_reg) >= w;
        c     = wrap ? '0 : col_reg;
        r_try = wrap ? H_W'(row_reg) + H_W'(1) : H_W'(row_reg);
        r     = (r_try >= h) ? h - H_W'(1) : r_try;

        step      = '0;
        step.valid = 1'b1;
        addr      = c;
        col_next  = col_reg;
        row_next  = row_reg;
        pend_next = pend_c;
        top_ok    = 1'b0;
        bot_ok    = 1'b0;
        left_ok   = 1'b0;
        right_ok  = 1'b0;

        if (pend_c != '0)
        begin
            step.feed = 1'b1;
            addr      = (d < w) ? CW'(d) : '0;
            step.emit = !(h == H_W'(1) && d == '0);
            step.last = pend_c == WW'(1);
            pend_next = pend_c - WW'(1);
            if (d == '0)
            begin
                top_ok   = h >= H_W'(3);
                bot_ok   = 1'b1;
                left_ok  = w >= WW'(2);
                right_ok = 1'b0;
            end
            else
            begin
                top_ok   = h >= H_W'(2);
                bot_ok   = 1'b0;
                left_ok  = d >= WW'(2);
                right_ok = d < w;
            end
        end
        else if (!in_kind)
        begin
            step.feed = 1'b1;
            step.pix  = in_pix;
            step.emit = (r >= H_W'(2)) || (r == H_W'(1) && c != '0);
            if (c != '0)
            begin
                top_ok   = r >= H_W'(2);
                bot_ok   = 1'b1;
                left_ok  = WW'(c) >= WW'(2);
                right_ok = 1'b1;
            end
            else
            begin
                top_ok   = r >= H_W'(3);
                bot_ok   = 1'b1;
                left_ok  = w >= WW'(2);
                right_ok = 1'b0;
            end
            if (r == h - H_W'(1) && WW'(c) == w - WW'(1))
            begin
                pend_next = w1;
                row_next  = '0;
                col_next  = '0;
            end
            else if (WW'(c) + WW'(1) < w)
            begin
                col_next = c + CW'(1);
                row_next = r[ROW_W-1:0];
            end
            else
            begin
                col_next = '0;
                row_next = ROW_W'(r + H_W'(1));
            end
        end

        rok = {bot_ok, 1'b1, top_ok};
        cok = {right_ok, 1'b1, left_ok};
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                step.mask[i * 3 + j] = rok[i] & cok[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            pend_reg <= '0;
            s1_step  <= '0;
            s1_addr  <= '0;
        end
        else if (adv)
        begin
            s1_step <= accept ? step : '0;
            s1_addr <= addr;
            if (accept)
            begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                pend_reg <= pend_next;
            end
        end
    end

endmodule

FILE: sv/rgbc_mac.sv
// Window update with line store write-back, tap products, sums and clamping.
module rgbc_mac import rgbc_pkg::*; #(
    parameter int MAX_WIDTH      = MAX_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  cfg_t                         cfg,
    input  step_t                        s1_step,
    input  logic [$clog2(MAX_WIDTH)-1:0] s1_addr,
    input  logic [PIX_W-1:0]             older_rd,
    input  logic [PIX_W-1:0]             newer_rd,
    output logic                         ram_we,
    output logic [$clog2(MAX_WIDTH)-1:0] ram_waddr,
    output logic [PIX_W-1:0]             older_wd,
    output logic [PIX_W-1:0]             newer_wd,
    output logic                         out_valid,
    output logic [PIX_W-1:0]             out_pix,
    output logic                         out_last
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int PW    = 25;
    localparam int SW    = 27;
    localparam int TW    = 29;

    logic                fwd_valid_reg;
    logic [CW-1:0]       fwd_addr_reg;
    logic [PIX_W-1:0]    fwd_mid_reg, fwd_pix_reg;
    logic                fwd_hit;
    logic [PIX_W-1:0]    col_top, col_mid;

    logic [PIX_W-1:0]    win_reg [TAPS];
    logic                v2_reg, last2_reg;
    logic [TAPS-1:0]     mask2_reg;

    logic signed [COEF_W-1:0] coef [TAPS];
    logic signed [PW-1:0]     prod_reg [3][TAPS];
    logic                     v3_reg, last3_reg;
    logic signed [SW-1:0]     rsum_reg [3][3];
    logic                     v4_reg, last4_reg;
    logic signed [TW-1:0]     total [3];
    logic signed [TW-1:0]     shifted [3];
    logic [7:0]               clamped [3];
    logic                     out_valid_reg, out_last_reg;
    logic [PIX_W-1:0]         out_pix_reg;

    // the entry written on the previous advance is not yet visible to this read
    assign fwd_hit   = fwd_valid_reg && fwd_addr_reg == s1_addr;
    assign col_top   = fwd_hit ? fwd_mid_reg : older_rd;
    assign col_mid   = fwd_hit ? fwd_pix_reg : newer_rd;
    assign ram_we    = adv && s1_step.valid && s1_step.feed;
    assign ram_waddr = s1_addr;
    assign older_wd  = col_mid;
    assign newer_wd  = s1_step.pix;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            coef[j]     = $signed(cfg.k_top[COEF_W * j +: COEF_W]);
            coef[3 + j] = $signed(cfg.k_mid[COEF_W * j +: COEF_W]);
            coef[6 + j] = $signed(cfg.k_bot[COEF_W * j +: COEF_W]);
        end
        for (int ch = 0; ch < 3; ch++)
        begin
            total[ch]   = TW'(rsum_reg[ch][0]) + TW'(rsum_reg[ch][1]) + TW'(rsum_reg[ch][2]);
            shifted[ch] = total[ch] >>> COEF_FRAC_BITS;
            if (total[ch] < 0)
                clamped[ch] = 8'd0;
            else if (shifted[ch] > TW'(255))
                clamped[ch] = 8'd255;
            else
                clamped[ch] = shifted[ch][7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int t = 0; t < TAPS; t++)
            begin
                win_reg[t] <= '0;
            end
        end
        else if (adv)
        begin
            fwd_valid_reg <= ram_we;
            if (s1_step.valid && s1_step.feed)
            begin
                for (int rr = 0; rr < 3; rr++)
                begin
                    win_reg[rr * 3]     <= win_reg[rr * 3 + 1];
                    win_reg[rr * 3 + 1] <= win_reg[rr * 3 + 2];
                end
                win_reg[2] <= col_top;
                win_reg[5] <= col_mid;
                win_reg[8] <= s1_step.pix;
            end
            v2_reg        <= s1_step.valid && s1_step.emit;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fwd_addr_reg <= s1_addr;
            fwd_mid_reg  <= col_mid;
            fwd_pix_reg  <= s1_step.pix;
            last2_reg    <= s1_step.last;
            mask2_reg    <= s1_step.mask;
            last3_reg    <= last2_reg;
            for (int ch = 0; ch < 3; ch++)
            begin
                for (int t = 0; t < TAPS; t++)
                begin
                    if (mask2_reg[t])
                        prod_reg[ch][t] <= $signed({1'b0, win_reg[t][8 * ch +: 8]}) * coef[t];
                    else
                        prod_reg[ch][t] <= '0;
                end
                for (int i = 0; i < 3; i++)
                begin
                    rsum_reg[ch][i] <= SW'(prod_reg[ch][i * 3]) + SW'(prod_reg[ch][i * 3 + 1])
                                     + SW'(prod_reg[ch][i * 3 + 2]);
                end
                out_pix_reg[8 * ch +: 8] <= clamped[ch];
            end
            last4_reg    <= last3_reg;
            out_last_reg <= last4_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pix   = out_pix_reg;
    assign out_last  = out_last_reg;

endmodule

FILE: sv/rgb_convolution_3x3_clamped.sv
// Top level of the zero-padded 3x3 RGB convolution with clamped output.
// Stages: step register, window, tap products, row sums, output register.
// Throughput: one word per cycle; the whole pipeline holds while the output waits.
// Line store read-modify-write forwards the entry written one advance earlier.
// Reset (rst_n low, asynchronous) clears position, drain count, window and valids;
// the line stores need no clearing, entries never written only feed masked taps.
module rgb_convolution_3x3_clamped import rgbc_pkg::*; #(
    parameter int MAX_WIDTH      = MAX_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
    input  logic [0:0]        s_tuser,   // kind[0]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,   // red_out[7:0], green_out[15:8], blue_out[23:16]
    output logic              m_tlast,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int CW = $clog2(MAX_WIDTH);

    cfg_t             cfg;
    logic             adv;
    logic [CW-1:0]    rd_addr, s1_addr, ram_waddr;
    step_t            s1_step;
    logic [PIX_W-1:0] older_rd, newer_rd, older_wd, newer_wd;
    logic             ram_we;

    assign pready   = 1'b1;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    rgbc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    rgbc_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (s_tvalid),
        .in_kind  (s_tuser[0]),
        .in_pix   (s_tdata),
        .adv      (adv),
        .rd_addr  (rd_addr),
        .s1_step  (s1_step),
        .s1_addr  (s1_addr)
    );

    rgbc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (older_wd),
        .re    (adv),
        .raddr (rd_addr),
        .rdata (older_rd)
    );

    rgbc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (newer_wd),
        .re    (adv),
        .raddr (rd_addr),
        .rdata (newer_rd)
    );

    rgbc_mac #(.MAX_WIDTH(MAX_WIDTH), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .cfg       (cfg),
        .s1_step   (s1_step),
        .s1_addr   (s1_addr),
        .older_rd  (older_rd),
        .newer_rd  (newer_rd),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .older_wd  (older_wd),
        .newer_wd  (newer_wd),
        .out_valid (m_tvalid),
        .out_pix   (m_tdata),
        .out_last  (m_tlast)
    );

`ifndef NO_ASSERTIONS
    // write back only on a pipeline advance, never while the output is stalled
    a_write_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> s_tready)
        else $error("line store written during a stall");

    // a word that does not move the window must leave the line stores alone
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!s1_step.valid || !s1_step.feed) |-> !ram_we)
        else $error("line store written without a feeding word");

    // a stalled result keeps the pipeline frozen for the next cycle
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> ($stable(s1_step) && $stable(s1_addr)))
        else $error("pipeline moved under a stalled result");
`endif

endmodule
